FILE: hw/rtl/fwrbv_pkg.sv
// Package for the queue with remove-by-value: action and status codes,
// and the control word broadcast to the row of storage cells.
// No dependencies.
package fwrbv_pkg;

   localparam int DataWidth  = 32;
   localparam int CountWidth = 5;

   typedef enum logic [1:0] {
      ACT_ENQ = 2'd0,
      ACT_DEQ = 2'd1,
      ACT_REM = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic                        enq_en;
      logic                        deq_en;
      logic                        rem_en;
      logic signed [DataWidth-1:0] value;
   } cell_ctl_type;

endpackage

FILE: hw/rtl/fwrbv_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on fwrbv_pkg for field widths.
interface fwrbv_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            action;
   logic signed [fwrbv_pkg::DataWidth-1:0] data_value;

   modport source (output valid, output action, output data_value, input ready);
   modport sink   (input valid, input action, input data_value, output ready);
endinterface

interface fwrbv_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             status;
   logic signed [fwrbv_pkg::DataWidth-1:0]  taken_value;
   logic signed [fwrbv_pkg::DataWidth-1:0]  head_value;
   logic signed [fwrbv_pkg::DataWidth-1:0]  tail_value;
   logic [fwrbv_pkg::CountWidth-1:0]       item_count;
   logic                                   is_empty;

   modport source (output valid, output status, output taken_value, output head_value,
                   output tail_value, output item_count, output is_empty, input ready);
   modport sink   (input valid, input status, input taken_value, input head_value,
                   input tail_value, input item_count, input is_empty, output ready);
endinterface

FILE: hw/rtl/fwrbv_cell.sv
// One storage cell of the queue: holds a single entry, takes part in the
// first-match chain and shifts in its neighbour's entry to close a gap. Uses fwrbv_pkg.
module fwrbv_cell #(
   parameter int DEPTH = 16,
   parameter int INDEX = 0,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic                                   clock,
   input  fwrbv_pkg::cell_ctl_type                ctl,
   input  logic [CW-1:0]                          count,
   input  logic                                   found_in,
   output logic                                   found_out,
   input  logic signed [fwrbv_pkg::DataWidth-1:0] next_data,
   output logic signed [fwrbv_pkg::DataWidth-1:0] data_out
);

   logic signed [fwrbv_pkg::DataWidth-1:0] data_ff;
   logic signed [fwrbv_pkg::DataWidth-1:0] data_in;
   logic                                   live;
   logic                                   hit;

   assign live      = CW'(INDEX) < count;
   assign hit       = ctl.rem_en && live && (data_ff == ctl.value);
   assign found_out = found_in || hit;
   assign data_out  = data_ff;

   always_comb begin
      data_in = data_ff;
      if (found_out && live) begin
         data_in = next_data;
      end else if (ctl.enq_en && (CW'(INDEX) == count)) begin
         data_in = ctl.value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

FILE: hw/rtl/fifo_with_remove_by_value_top.sv
// Queue with remove-by-value: a row of DEPTH cells, head in cell 0.
// Result registered and presented in the cycle after the request transfer.
// Throughput: one request per cycle while no response is held back; the
// critical path is the first-match chain rippling through all DEPTH cells.
// Reset: clears the entry count and the pending response; cell contents are
// left as they are. Depends on fwrbv_pkg, fwrbv_if and fwrbv_cell.
module fifo_with_remove_by_value_top #(
   parameter int DEPTH = 16
) (
   input logic           clock,
   input logic           reset,
   fwrbv_req_if.sink     req_if,
   fwrbv_rsp_if.source   rsp_if
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = fwrbv_pkg::DataWidth;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   fwrbv_pkg::status_type   status_ff;
   fwrbv_pkg::status_type   status_in;
   logic signed [DW-1:0]    taken_ff;
   logic signed [DW-1:0]    taken_in;

   logic                    req_xfer;
   logic                    full;
   logic                    empty;
   fwrbv_pkg::cell_ctl_type ctl;
   logic [DEPTH:0]          found;
   logic signed [DW-1:0]    cell_data [DEPTH];
   logic signed [DW-1:0]    tail_sel;
   logic [CW+4:0]           count_wide;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_xfer     = req_if.valid && req_if.ready;
   assign full         = count_ff == CW'(DEPTH);
   assign empty        = count_ff == '0;

   always_comb begin
      ctl.enq_en = 1'b0;
      ctl.deq_en = 1'b0;
      ctl.rem_en = 1'b0;
      ctl.value  = req_if.data_value;
      if (req_xfer) begin
         case (fwrbv_pkg::action_type'(req_if.action))
            fwrbv_pkg::ACT_ENQ: ctl.enq_en = !full;
            fwrbv_pkg::ACT_DEQ: ctl.deq_en = !empty;
            fwrbv_pkg::ACT_REM: ctl.rem_en = 1'b1;
            default: ;
         endcase
      end
   end

   assign found[0] = ctl.deq_en;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DW-1:0] next_data;
      if (i == DEPTH - 1) begin : g_last
         assign next_data = cell_data[i];
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end
      fwrbv_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (count_ff),
         .found_in  (found[i]),
         .found_out (found[i+1]),
         .next_data (next_data),
         .data_out  (cell_data[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      taken_in  = taken_ff;
      if (req_xfer) begin
         status_in = fwrbv_pkg::ST_OK;
         taken_in  = '0;
         case (fwrbv_pkg::action_type'(req_if.action))
            fwrbv_pkg::ACT_ENQ: begin
               if (full) begin
                  status_in = fwrbv_pkg::ST_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            fwrbv_pkg::ACT_DEQ: begin
               if (empty) begin
                  status_in = fwrbv_pkg::ST_EMPTY;
                  taken_in  = '1;
               end else begin
                  taken_in = cell_data[0];
                  count_in = count_ff - CW'(1);
               end
            end
            fwrbv_pkg::ACT_REM: begin
               if (found[DEPTH]) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  status_in = fwrbv_pkg::ST_NOTFOUND;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      status_ff <= status_in;
      taken_ff  <= taken_in;
   end

   always_comb begin
      tail_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CW'(i + 1) == count_ff) begin
            tail_sel = tail_sel | cell_data[i];
         end
      end
   end

   assign count_wide = {5'b0, count_ff};

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.taken_value = taken_ff;
   assign rsp_if.head_value  = empty ? '0 : cell_data[0];
   assign rsp_if.tail_value  = tail_sel;
   assign rsp_if.item_count  = count_wide[4:0];
   assign rsp_if.is_empty    = empty;

endmodule

FILE: hw/rtl/fwrbv_checker.sv
// Port-level checks for the queue with remove-by-value, bound to the top.
// Depends on fwrbv_pkg.
module fwrbv_checker #(
   parameter int DEPTH = 16
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [1:0]                             rsp_status,
   input logic signed [fwrbv_pkg::DataWidth-1:0] rsp_taken,
   input logic signed [fwrbv_pkg::DataWidth-1:0] rsp_head,
   input logic signed [fwrbv_pkg::DataWidth-1:0] rsp_tail,
   input logic [fwrbv_pkg::CountWidth-1:0]       rsp_count,
   input logic                                   rsp_empty
);

   localparam int CW = fwrbv_pkg::CountWidth;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && DEPTH < 32 |-> (rsp_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   a_empty_deq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fwrbv_pkg::ST_EMPTY |-> rsp_empty && rsp_taken == -1)
      else $error("dequeue on empty queue misreported");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty |-> rsp_head == '0 && rsp_tail == '0)
      else $error("head or tail nonzero on empty queue");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && DEPTH < 32 |-> rsp_count <= CW'(DEPTH))
      else $error("count above depth");

endmodule

bind fifo_with_remove_by_value_top fwrbv_checker #(
   .DEPTH (DEPTH)
) u_fwrbv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_status (rsp_if.status),
   .rsp_taken  (rsp_if.taken_value),
   .rsp_head   (rsp_if.head_value),
   .rsp_tail   (rsp_if.tail_value),
   .rsp_count  (rsp_if.item_count),
   .rsp_empty  (rsp_if.is_empty)
);
